// ----- src/prfl_pkg.sv -----
// prfl_pkg: widths, sizes and register indexes of the page replacement unit
// no dependencies; compile before the channel interfaces and the top level
`default_nettype none

package prfl_pkg;

  // page table and load ring sizes, fixed by the 5-bit page and frame fields
  localparam int NUM_PAGES  = 32;
  localparam int MAX_FRAMES = 32;

  localparam int PAGE_W  = 5;
  localparam int FRAME_W = 5;
  localparam int CNT_W   = 6;
  localparam int TIME_W  = 32;
  localparam int TOTAL_W = 16;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_POLICY = 1'd0;
  localparam cfg_idx_t CFG_FRAMES = 1'd1;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  localparam logic [CNT_W-1:0] FRAMES_RESET = 6'd4;

endpackage

`default_nettype wire

// ----- src/prfl_req_if.sv -----
// prfl_req_if: request channel, one page reference per transaction
// depends on prfl_pkg
`default_nettype none

interface prfl_req_if import prfl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

`default_nettype wire

// ----- src/prfl_rsp_if.sv -----
// prfl_rsp_if: response channel, one lookup result per transaction
// depends on prfl_pkg
`default_nettype none

interface prfl_rsp_if import prfl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               fault;
  logic [FRAME_W-1:0] frame;
  logic               evicted_valid;
  logic [PAGE_W-1:0]  evicted_page;
  logic [TOTAL_W-1:0] fault_total;

  modport source (output valid, output fault, output frame, output evicted_valid,
                  output evicted_page, output fault_total, input ready);
  modport sink   (input valid, input fault, input frame, input evicted_valid,
                  input evicted_page, input fault_total, output ready);
endinterface

`default_nettype wire

// ----- src/prfl_cfg_if.sv -----
// prfl_cfg_if: configuration write channel, register index and data
// depends on prfl_pkg
`default_nettype none

interface prfl_cfg_if import prfl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/page_replacement_fifo_lru.sv -----
// page_replacement_fifo_lru: page table with FIFO or LRU frame replacement
// depends on prfl_pkg, prfl_req_if, prfl_rsp_if, prfl_cfg_if
//
//   channel  dir  payload                                              notes
//   req      in   page_number                                          one reference
//   rsp      out  fault, frame, evicted_valid, evicted_page,           one result
//                 fault_total                                          per reference
//   cfg      in   index, data                                          always ready
//
// one reference at a time; a hit or a miss into a free frame goes from the
// lookup state to the commit state, a FIFO eviction reads back the victim frame
// in between; an LRU eviction first sweeps the last-use memory for the oldest
// page, then makes a pass over the load ring to take the victim out and close
// the gap (one ring read and write per cycle); req is ready again as soon as
// the response register loads
// reset clears only flops; the page table memories hold nothing meaningful
// until written and their contents are used only for resident pages or live ring slots
// a stalled response holds its register and the unit waits before loading it
`default_nettype none

module page_replacement_fifo_lru import prfl_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  prfl_req_if.sink   req,
  prfl_rsp_if.source rsp,
  prfl_cfg_if.sink   cfg
);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;  // waiting for a reference
  localparam logic [2:0] S_LOOK   = 3'd1;  // page table read back, classify
  localparam logic [2:0] S_SCAN   = 3'd2;  // lru: sweep last-use times
  localparam logic [2:0] S_RING   = 3'd3;  // lru: drop victim from load ring
  localparam logic [2:0] S_FVIC   = 3'd4;  // victim frame read back
  localparam logic [2:0] S_COMMIT = 3'd5;  // write page table and ring
  localparam logic [2:0] S_FIN    = 3'd6;  // hand result to response register

  // configuration registers
  logic             policy;
  logic [CNT_W-1:0] frames_in_use;

  // control state
  logic [2:0]           state;
  logic [NUM_PAGES-1:0] resident;
  logic [TIME_W-1:0]    use_clock;
  logic [PAGE_W-1:0]    order_head;
  logic [CNT_W-1:0]     order_count;
  logic [CNT_W-1:0]     frames_taken;
  logic [TOTAL_W-1:0]   fault_count;

  // per-reference working registers
  logic [PAGE_W-1:0]  pg;
  logic               hit;
  logic [FRAME_W-1:0] frame_sel;
  logic               ev_valid;
  logic [PAGE_W-1:0]  victim;

  // sweep counter and check stage, shared by the lru scan and the ring pass
  logic [CNT_W-1:0]  cnt;
  logic              chk_valid;
  logic [PAGE_W-1:0] chk_idx;
  logic              found;
  logic              best_found;
  logic [PAGE_W-1:0] best_page;
  logic [TIME_W-1:0] best_age;

  // response register
  logic               out_valid;
  logic               out_fault;
  logic [FRAME_W-1:0] out_frame;
  logic               out_ev_valid;
  logic [PAGE_W-1:0]  out_ev_page;
  logic [TOTAL_W-1:0] out_total;

  // memories with registered read data
  logic [FRAME_W-1:0] frame_mem   [NUM_PAGES];
  logic [TIME_W-1:0]  lastuse_mem [NUM_PAGES];
  logic [PAGE_W-1:0]  ring_mem    [MAX_FRAMES];

  logic [PAGE_W-1:0]  frame_rd_addr;
  logic [FRAME_W-1:0] frame_rdata;
  logic [PAGE_W-1:0]  lastuse_rd_addr;
  logic [TIME_W-1:0]  lastuse_rdata;
  logic [PAGE_W-1:0]  ring_rd_addr;
  logic [PAGE_W-1:0]  ring_rdata;
  logic               ring_we;
  logic [PAGE_W-1:0]  ring_wa;
  logic [PAGE_W-1:0]  ring_wd;

  logic               req_fire;
  logic               rsp_fire;
  logic [CNT_W-1:0]   frame_limit;
  logic [TIME_W-1:0]  age;
  logic               scan_take;
  logic               scan_last;
  logic               ring_match;
  logic               ring_last;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign req_fire  = req.valid && req.ready;
  assign rsp_fire  = out_valid && rsp.ready;

  assign rsp.valid         = out_valid;
  assign rsp.fault         = out_fault;
  assign rsp.frame         = out_frame;
  assign rsp.evicted_valid = out_ev_valid;
  assign rsp.evicted_page  = out_ev_page;
  assign rsp.fault_total   = out_total;

  // zero counts as one frame, anything above the ring size as the ring size
  always_comb begin
    if (frames_in_use == '0) begin
      frame_limit = CNT_W'(1);
    end else if (frames_in_use > CNT_W'(MAX_FRAMES)) begin
      frame_limit = CNT_W'(MAX_FRAMES);
    end else begin
      frame_limit = frames_in_use;
    end
  end

  // lru check stage: ages are modulo 2^32, ties keep the lower page
  assign age       = use_clock - lastuse_rdata;
  assign scan_take = chk_valid && resident[chk_idx] && (!best_found || age > best_age);
  assign scan_last = chk_valid && (chk_idx == PAGE_W'(NUM_PAGES - 1));

  // ring pass check stage
  assign ring_match = chk_valid && !found && (ring_rdata == victim);
  assign ring_last  = chk_valid && ({1'b0, chk_idx} == order_count - CNT_W'(1));

  // read address selection
  always_comb begin
    case (state)
      S_IDLE:  frame_rd_addr = req.page_number;
      S_LOOK:  frame_rd_addr = ring_rdata;      // fifo victim at the ring head
      default: frame_rd_addr = victim;
    endcase
  end

  assign lastuse_rd_addr = cnt[PAGE_W-1:0];
  assign ring_rd_addr    = (state == S_RING) ? order_head + cnt[PAGE_W-1:0] : order_head;

  // ring write port: gap closing during the ring pass, append at commit
  always_comb begin
    ring_we = 1'b0;
    ring_wa = order_head + order_count[PAGE_W-1:0];
    ring_wd = pg;
    if (state == S_RING && chk_valid && found) begin
      ring_we = 1'b1;
      ring_wa = order_head + chk_idx - PAGE_W'(1);
      ring_wd = ring_rdata;
    end else if (state == S_COMMIT && !hit && order_count < CNT_W'(MAX_FRAMES)) begin
      ring_we = 1'b1;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    frame_rdata <= frame_mem[frame_rd_addr];
    if (state == S_COMMIT) begin
      frame_mem[pg] <= frame_sel;
    end
  end

  always_ff @(posedge clk) begin
    lastuse_rdata <= lastuse_mem[lastuse_rd_addr];
    if (state == S_COMMIT) begin
      lastuse_mem[pg] <= use_clock;
    end
  end

  always_ff @(posedge clk) begin
    ring_rdata <= ring_mem[ring_rd_addr];
    if (ring_we) begin
      ring_mem[ring_wa] <= ring_wd;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          pg       <= req.page_number;
          hit      <= resident[req.page_number];
          ev_valid <= 1'b0;
        end
      end
      S_LOOK: begin
        if (hit) begin
          frame_sel <= frame_rdata;
        end else if (frames_taken < frame_limit) begin
          frame_sel <= frames_taken[FRAME_W-1:0];
        end else if (order_count == '0) begin
          frame_sel <= '0;
        end else if (policy == POLICY_FIFO) begin
          victim   <= ring_rdata;
          ev_valid <= 1'b1;
        end
      end
      S_SCAN: begin
        if (scan_take) begin
          best_page <= chk_idx;
          best_age  <= age;
        end
        if (scan_last) begin
          victim   <= scan_take ? chk_idx : best_page;
          ev_valid <= 1'b1;
        end
      end
      S_FVIC: begin
        frame_sel <= frame_rdata;
      end
      default: begin
      end
    endcase
    if ((state == S_SCAN || state == S_RING)) begin
      chk_idx <= cnt[PAGE_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      policy        <= POLICY_FIFO;
      frames_in_use <= FRAMES_RESET;
      resident      <= '0;
      use_clock     <= '0;
      order_head    <= '0;
      order_count   <= '0;
      frames_taken  <= '0;
      fault_count   <= '0;
      cnt           <= '0;
      chk_valid     <= 1'b0;
      found         <= 1'b0;
      best_found    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_POLICY: policy        <= cfg.data[0];
          CFG_FRAMES: frames_in_use <= cfg.data;
          default: begin
          end
        endcase
      end

      // the final stage reloads the register in the same cycle it drains
      if (rsp_fire && state != S_FIN) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_fire) begin
            state <= S_LOOK;
          end
        end

        S_LOOK: begin
          if (hit) begin
            state <= S_COMMIT;
          end else if (frames_taken < frame_limit) begin
            frames_taken <= frames_taken + CNT_W'(1);
            state        <= S_COMMIT;
          end else if (order_count == '0) begin
            state <= S_COMMIT;
          end else if (policy == POLICY_FIFO) begin
            // pop the ring head; its frame comes back next cycle
            order_head  <= order_head + PAGE_W'(1);
            order_count <= order_count - CNT_W'(1);
            state       <= S_FVIC;
          end else begin
            cnt        <= '0;
            chk_valid  <= 1'b0;
            best_found <= 1'b0;
            state      <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (scan_take) begin
            best_found <= 1'b1;
          end
          if (scan_last) begin
            cnt       <= '0;
            chk_valid <= 1'b0;
            found     <= 1'b0;
            state     <= S_RING;
          end else if (cnt < CNT_W'(NUM_PAGES)) begin
            cnt       <= cnt + CNT_W'(1);
            chk_valid <= 1'b1;
          end else begin
            chk_valid <= 1'b0;
          end
        end

        S_RING: begin
          if (ring_match) begin
            found <= 1'b1;
          end
          if (ring_last) begin
            chk_valid <= 1'b0;
            if (found || ring_match) begin
              order_count <= order_count - CNT_W'(1);
            end
            state <= S_FVIC;
          end else if (cnt < order_count) begin
            cnt       <= cnt + CNT_W'(1);
            chk_valid <= 1'b1;
          end else begin
            chk_valid <= 1'b0;
          end
        end

        S_FVIC: begin
          state <= S_COMMIT;
        end

        S_COMMIT: begin
          // drop the victim and mark the referenced page in one update
          resident  <= (resident & ~(NUM_PAGES'(ev_valid) << victim))
                     | (NUM_PAGES'(1) << pg);
          use_clock <= use_clock + TIME_W'(1);
          if (!hit) begin
            if (fault_count != '1) begin
              fault_count <= fault_count + TOTAL_W'(1);
            end
            if (order_count < CNT_W'(MAX_FRAMES)) begin
              order_count <= order_count + CNT_W'(1);
            end
          end
          state <= S_FIN;
        end

        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid    <= 1'b1;
            out_fault    <= !hit;
            out_frame    <= frame_sel;
            out_ev_valid <= ev_valid;
            out_ev_page  <= ev_valid ? victim : '0;
            out_total    <= fault_count;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the load ring holds as many entries as there are resident pages between references
  a_ring_matches_resident: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(resident) == 32'(order_count)))
    else $error("load ring count differs from resident page count");

  // an evicted page must have been resident
  a_victim_resident: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT && ev_valid) |-> resident[victim])
    else $error("eviction of a page that is not resident");

  // a page being loaded on a miss was not resident
  a_miss_not_resident: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT && !hit) |-> !resident[pg])
    else $error("miss on a resident page");

  // frames are handed out no further than the ring size
  a_frames_bounded: assert property (@(posedge clk) disable iff (rst)
    (frames_taken <= CNT_W'(MAX_FRAMES)) && (order_count <= CNT_W'(MAX_FRAMES)))
    else $error("frame or ring count beyond ring size");

  // the fault total never goes backward
  a_faults_monotonic: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT) |=> (fault_count >= $past(fault_count)))
    else $error("fault total decreased");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench: self-checking bench for the FIFO/LRU page replacement unit
// drives req and cfg, predicts every response, checks rsp field by field
// depends on prfl_pkg, the prfl channel interfaces and page_replacement_fifo_lru
`timescale 1ns / 1ps

module testbench;
  import prfl_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 130;
  // give the tail some slack beyond the worst lru eviction
  localparam int TAIL_CYCLES   = 100;
  // room for ~1350 transactions at their worst case, several times over
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // directed traces; the unit starts in fifo mode with four frames
  // fill frames 0..3, hit page 0, then fifo evicts page 0 despite the hit
  localparam logic [PAGE_W-1:0] FIFO_TRACE [9] = '{
    5'd0, 5'd31, 5'd0, 5'd1, 5'd2, 5'd5, 5'd31, 5'd10, 5'd21
  };
  // lru: refresh three pages so the untouched one is the victim
  localparam logic [PAGE_W-1:0] LRU_TRACE [10] = '{
    5'd2, 5'd21, 5'd5, 5'd7, 5'd2, 5'd9, 5'd31, 5'd7, 5'd0, 5'd2
  };
  // back to fifo with a zero frame limit, ring must be intact after lru removals
  localparam logic [PAGE_W-1:0] ZERO_LIMIT_TRACE [3] = '{5'd4, 5'd4, 5'd1};

  // frame limits for the first random phases: minimum, maximum, clamped values
  localparam logic [CNT_W-1:0] FRAME_PLAN [6] = '{
    6'd1, 6'd32, 6'd63, 6'd33, 6'd2, 6'd8
  };

  typedef struct packed {
    logic               fault;
    logic [FRAME_W-1:0] frame;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [TOTAL_W-1:0] fault_total;
  } page_result_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_HOLD} sink_mode_t;

  // page table predictor plus the queue of responses it expects
  class page_table_scoreboard;
    logic               policy;
    logic [CNT_W-1:0]   frames_in_use;
    bit                 resident [NUM_PAGES];
    logic [FRAME_W-1:0] page_frame [NUM_PAGES];
    logic [TIME_W-1:0]  last_use [NUM_PAGES];
    logic [TIME_W-1:0]  use_clock;
    logic [PAGE_W-1:0]  load_order [MAX_FRAMES];
    int                 order_head;
    int                 order_count;
    int                 frames_taken;
    logic [TOTAL_W-1:0] fault_count;
    page_result_t       expected_q [$];
    int                 errors;

    function new();
      policy        = POLICY_FIFO;
      frames_in_use = FRAMES_RESET;
      foreach (resident[j]) resident[j] = 1'b0;
      use_clock     = '0;
      order_head    = 0;
      order_count   = 0;
      frames_taken  = 0;
      fault_count   = '0;
      errors        = 0;
    endfunction

    function int ring_slot(int offset);
      return (order_head + offset) % MAX_FRAMES;
    endfunction

    function void apply_config(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_POLICY) policy = value[0];
      else if (idx == CFG_FRAMES) frames_in_use = value[CNT_W-1:0];
    endfunction

    // one accepted reference: update the table and queue the response
    function void note_request(logic [PAGE_W-1:0] pg);
      page_result_t      res;
      int                limit;
      int                victim;
      int                pos;
      bit                found;
      logic [TIME_W-1:0] age;
      logic [TIME_W-1:0] best_age;
      res = '0;
      if (resident[pg]) begin
        res.frame = page_frame[pg];
      end else begin
        res.fault = 1'b1;
        if (fault_count != '1) fault_count++;
        limit = (frames_in_use == 0) ? 1 :
                (frames_in_use > MAX_FRAMES) ? MAX_FRAMES : int'(frames_in_use);
        if (frames_taken < limit) begin
          res.frame = FRAME_W'(frames_taken);
          frames_taken++;
        end else if (order_count == 0) begin
          res.frame = '0;
        end else begin
          if (policy == POLICY_FIFO) begin
            victim      = load_order[order_head];
            order_head  = ring_slot(1);
            order_count--;
          end else begin
            // oldest age wins, lowest page on a tie
            found    = 1'b0;
            victim   = 0;
            best_age = '0;
            for (int j = 0; j < NUM_PAGES; j++) begin
              if (resident[j]) begin
                age = use_clock - last_use[j];
                if (!found || age > best_age) begin
                  victim   = j;
                  best_age = age;
                  found    = 1'b1;
                end
              end
            end
            // take the victim out of the load ring and close the gap
            pos = order_count;
            for (int k = 0; k < order_count; k++) begin
              if (load_order[ring_slot(k)] == victim) begin
                pos = k;
                break;
              end
            end
            if (pos != order_count) begin
              for (int k = pos; k + 1 < order_count; k++)
                load_order[ring_slot(k)] = load_order[ring_slot(k + 1)];
              order_count--;
            end
          end
          res.frame         = page_frame[victim];
          resident[victim]  = 1'b0;
          res.evicted_valid = 1'b1;
          res.evicted_page  = PAGE_W'(victim);
        end
        resident[pg]   = 1'b1;
        page_frame[pg] = res.frame;
        if (order_count < MAX_FRAMES) begin
          load_order[ring_slot(order_count)] = pg;
          order_count++;
        end
      end
      last_use[pg] = use_clock;
      use_clock++;
      res.fault_total = fault_count;
      expected_q.push_back(res);
    endfunction

    function void compare_field(string field, logic [TOTAL_W-1:0] want,
                                logic [TOTAL_W-1:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
        errors++;
      end
    endfunction

    function void check_response(page_result_t seen);
      page_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual %h", $time, seen);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("fault", TOTAL_W'(want.fault), TOTAL_W'(seen.fault));
      compare_field("frame", TOTAL_W'(want.frame), TOTAL_W'(seen.frame));
      compare_field("evicted_valid", TOTAL_W'(want.evicted_valid),
                    TOTAL_W'(seen.evicted_valid));
      compare_field("evicted_page", TOTAL_W'(want.evicted_page),
                    TOTAL_W'(seen.evicted_page));
      compare_field("fault_total", want.fault_total, seen.fault_total);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  prfl_req_if req_ch ();
  prfl_rsp_if rsp_ch ();
  prfl_cfg_if cfg_ch ();

  page_replacement_fifo_lru u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  page_table_scoreboard sb;
  int unsigned          cycle_count = 0;
  sink_mode_t           sink_mode   = SINK_OPEN;
  int                   sink_left   = 0;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("page_replacement_fifo_lru verification failed");
      $finish;
    end
  end

  // response side: check each rsp transaction, then pick the next ready value
  // the sink runs in segments: always ready, coin toss, or a long hold
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_response('{fault: rsp_ch.fault, frame: rsp_ch.frame,
                          evicted_valid: rsp_ch.evicted_valid,
                          evicted_page: rsp_ch.evicted_page,
                          fault_total: rsp_ch.fault_total});
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 2));
      sink_left = (sink_mode == SINK_HOLD) ? $urandom_range(4, 24) : $urandom_range(10, 80);
    end
    sink_left--;
    case (sink_mode)
      SINK_OPEN: rsp_ch.ready <= 1'b1;
      SINK_COIN: rsp_ch.ready <= 1'($urandom_range(0, 1));
      default:   rsp_ch.ready <= (sink_left == 0);
    endcase
  end

  // hold the request side until every predicted response is back
  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // one req transaction; valid is left high for a following reference
  task automatic send_page(input logic [PAGE_W-1:0] pg);
    req_ch.valid       <= 1'b1;
    req_ch.page_number <= pg;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(pg);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.apply_config(idx, value);
  endtask

  // only called with the unit idle; upper policy bits are don't-care noise
  task automatic program_unit(input logic pol, input logic [CNT_W-1:0] frames);
    logic [CFG_DATA_W-1:0] pol_word;
    pol_word    = CFG_DATA_W'($urandom);
    pol_word[0] = pol;
    cfg_write(CFG_POLICY, pol_word);
    cfg_write(CFG_FRAMES, frames);
    cfg_ch.valid <= 1'b0;
  endtask

  // random references drawn mostly from a drifting working set of span + 1 pages,
  // sent in bursts with gaps and an occasional full drain
  task automatic run_references(input int count, input int span);
    int                sent;
    int                burst;
    int                gap;
    bit                drain;
    logic [PAGE_W-1:0] base;
    logic [PAGE_W-1:0] pg;
    base = PAGE_W'($urandom);
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      for (int b = 0; b < burst && sent < count; b++) begin
        if ($urandom_range(0, 7) == 0) base = PAGE_W'($urandom);
        if ($urandom_range(0, 9) == 0) pg = PAGE_W'($urandom);
        else pg = base + PAGE_W'($urandom_range(0, span));
        send_page(pg);
        sent++;
      end
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      drain = ($urandom_range(0, 24) == 0);
      if (gap > 0 || drain) begin
        req_ch.valid <= 1'b0;
        if (drain) wait_drained();
        else repeat (gap) @(posedge clk);
      end
    end
    req_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [CNT_W-1:0] frames;
    logic             pol;
    sb                 = new();
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.page_number = '0;
    rsp_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_POLICY;
    cfg_ch.data        = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: reset config, then lru, then fifo with a zero frame limit
    foreach (FIFO_TRACE[i]) send_page(FIFO_TRACE[i]);
    req_ch.valid <= 1'b0;
    wait_drained();
    program_unit(POLICY_LRU, 6'd4);
    foreach (LRU_TRACE[i]) send_page(LRU_TRACE[i]);
    req_ch.valid <= 1'b0;
    wait_drained();
    program_unit(POLICY_FIFO, 6'd0);
    foreach (ZERO_LIMIT_TRACE[i]) send_page(ZERO_LIMIT_TRACE[i]);
    req_ch.valid <= 1'b0;

    // random phases, each with its own policy and frame limit
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      if (ph < 6) begin
        frames = FRAME_PLAN[ph];
        pol    = (ph % 2 == 0) ? POLICY_LRU : POLICY_FIFO;
      end else begin
        frames = CNT_W'($urandom_range(0, 63));
        pol    = 1'($urandom_range(0, 1));
      end
      program_unit(pol, frames);
      run_references(PHASE_ITEMS, $urandom_range(1, 31));
    end

    wait_drained();
    // catch any stray response after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("page_replacement_fifo_lru verification clean");
    end else begin
      $display("page_replacement_fifo_lru verification failed");
    end
    $finish;
  end

endmodule
